/* hw/rtl/scc_pkg.sv */
// Shared types, widths and constants of the soft constraint coefficient block.
package scc_pkg;

  localparam int MassW    = 31;
  localparam int ErrW     = 32;
  localparam int FreqW    = 16;
  localparam int ZetaW    = 16;
  localparam int BaumW    = 17;
  localparam int StepW    = 24;
  localparam int OmRawW   = 47;
  localparam int OmW      = 31;
  localparam int SW       = 56;
  localparam int TmW      = 55;
  localparam int TmoW     = 86;
  localparam int BmW      = 49;
  localparam int RbW      = 34;
  localparam int DW       = 142;
  localparam int QuoW     = 33;
  localparam int GamNumW  = 122;
  localparam int SoftNumW = 174;
  localparam int SoftDenW = 143;
  localparam int BiasNumW = 89;
  localparam int FrontLat = 8;
  localparam int DivLat   = QuoW + 1;

  localparam logic [OmW-1:0] TwoPiQ28 = 31'd1686629713;

  localparam logic [BaumW-1:0] BaumReset = 17'd13107;
  localparam logic [StepW-1:0] StepReset = 24'd279620;

  localparam logic [0:0] CfgBaumgarte = 1'b0;
  localparam logic [0:0] CfgTimeStep  = 1'b1;

  typedef struct packed {
    logic [MassW-1:0]       effective_mass;
    logic signed [ErrW-1:0] position_error;
    logic [FreqW-1:0]       spring_frequency;
    logic [ZetaW-1:0]       damping_ratio;
  } scc_in_t;

  typedef struct packed {
    logic signed [31:0] bias_term;
    logic [30:0]        soft_mass;
    logic [30:0]        gamma_term;
    logic               saturated;
  } scc_out_t;

  typedef struct packed {
    logic rigid;
    logic tzero;
    logic neg;
  } scc_flags_t;

  typedef struct packed {
    scc_flags_t       flags;
    logic [MassW-1:0] mass;
    logic [RbW-1:0]   rigid_bias;
  } scc_side_t;

endpackage

/* hw/rtl/scc_front.sv */
// Multiplier front end: omega, spring sum S, divisor D and the three quotient operands.
module scc_front
  import scc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  scc_in_t             data_i,
  input  logic [BaumW-1:0]    baum_i,
  input  logic [StepW-1:0]    step_i,
  output logic                valid_o,
  output scc_side_t           side_o,
  output logic [DW-1:0]       gam_den_o,
  output logic [SoftNumW-1:0] soft_num_o,
  output logic [SoftDenW-1:0] soft_den_o,
  output logic [BiasNumW-1:0] bias_num_o,
  output logic [SW-1:0]       bias_den_o
);

  logic [FrontLat-1:0] v_q;

  // stage 1
  logic [OmRawW-1:0] s1_omraw_q;
  logic [BmW-1:0]    s1_bm_q;
  logic [TmW-1:0]    s1_tm_q;
  logic [MassW-1:0]  s1_m_q;
  logic [ZetaW-1:0]  s1_z_q;
  scc_flags_t        s1_flags_q;
  // stage 2
  logic [OmW-1:0]    s2_om_q;
  logic [TmW-1:0]    s2_to_q;
  logic [RbW-1:0]    s2_rb_q;
  logic [BmW-1:0]    s2_bm_q;
  logic [TmW-1:0]    s2_tm_q;
  logic [MassW-1:0]  s2_m_q;
  logic [ZetaW-1:0]  s2_z_q;
  scc_flags_t        s2_flags_q;
  // stage 3
  logic [SW-1:0]     s3_s_q;
  logic [62:0]       s3_ptm0_q;
  logic [53:0]       s3_ptm1_q;
  logic [62:0]       s3_pbm0_q;
  logic [47:0]       s3_pbm1_q;
  logic [MassW-1:0]  s3_m_q;
  logic [RbW-1:0]    s3_rb_q;
  scc_flags_t        s3_flags_q;
  // stage 4
  logic [TmoW-1:0]     s4_tmo_q;
  logic [BiasNumW-1:0] s4_bnum_q;
  logic [SW-1:0]       s4_s_q;
  logic [MassW-1:0]    s4_m_q;
  logic [RbW-1:0]      s4_rb_q;
  scc_flags_t          s4_flags_q;
  // stage 5
  logic [63:0]         s5_p00_q;
  logic [55:0]         s5_p01_q;
  logic [63:0]         s5_p10_q;
  logic [55:0]         s5_p11_q;
  logic [53:0]         s5_p20_q;
  logic [45:0]         s5_p21_q;
  logic [BiasNumW-1:0] s5_bnum_q;
  logic [SW-1:0]       s5_s_q;
  logic [MassW-1:0]    s5_m_q;
  logic [RbW-1:0]      s5_rb_q;
  scc_flags_t          s5_flags_q;
  // stage 6
  logic [DW-1:0]       s6_d_q;
  logic [BiasNumW-1:0] s6_bnum_q;
  logic [SW-1:0]       s6_s_q;
  logic [MassW-1:0]    s6_m_q;
  logic [RbW-1:0]      s6_rb_q;
  scc_flags_t          s6_flags_q;
  // stage 7
  logic [62:0]         s7_q0_q;
  logic [62:0]         s7_q1_q;
  logic [62:0]         s7_q2_q;
  logic [62:0]         s7_q3_q;
  logic [44:0]         s7_q4_q;
  logic [SoftDenW-1:0] s7_den_q;
  logic [DW-1:0]       s7_d_q;
  logic [BiasNumW-1:0] s7_bnum_q;
  logic [SW-1:0]       s7_s_q;
  logic [MassW-1:0]    s7_m_q;
  logic [RbW-1:0]      s7_rb_q;
  scc_flags_t          s7_flags_q;
  // stage 8
  logic [SoftNumW-1:0] s8_num_q;
  logic [SoftDenW-1:0] s8_den_q;
  logic [DW-1:0]       s8_d_q;
  logic [BiasNumW-1:0] s8_bnum_q;
  logic [SW-1:0]       s8_s_q;
  scc_side_t           s8_side_q;

  logic [ErrW-1:0] err;
  logic [ErrW-1:0] mag;
  logic [OmW-1:0]  om;

  assign err = data_i.position_error;
  assign mag = err[ErrW-1] ? (~err + 32'd1) : err;
  assign om  = OmW'((48'(s1_omraw_q) + 48'h8000) >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FrontLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_omraw_q       <= OmRawW'(data_i.spring_frequency) * OmRawW'(TwoPiQ28);
      s1_bm_q          <= BmW'(baum_i) * BmW'(mag);
      s1_tm_q          <= TmW'(step_i) * TmW'(data_i.effective_mass);
      s1_m_q           <= data_i.effective_mass;
      s1_z_q           <= data_i.damping_ratio;
      s1_flags_q.rigid <= (data_i.spring_frequency == '0) || (data_i.effective_mass == '0);
      s1_flags_q.tzero <= (step_i == '0);
      s1_flags_q.neg   <= err[ErrW-1];

      s2_om_q    <= om;
      s2_to_q    <= TmW'(step_i) * TmW'(om);
      s2_rb_q    <= RbW'((50'(s1_bm_q) + 50'h8000) >> 16);
      s2_bm_q    <= s1_bm_q;
      s2_tm_q    <= s1_tm_q;
      s2_m_q     <= s1_m_q;
      s2_z_q     <= s1_z_q;
      s2_flags_q <= s1_flags_q;

      s3_s_q     <= (SW'(s2_z_q) << 37) + SW'(s2_to_q);
      s3_ptm0_q  <= 63'(s2_tm_q[31:0]) * 63'(s2_om_q);
      s3_ptm1_q  <= 54'(s2_tm_q[54:32]) * 54'(s2_om_q);
      s3_pbm0_q  <= 63'(s2_bm_q[31:0]) * 63'(s2_om_q);
      s3_pbm1_q  <= 48'(s2_bm_q[48:32]) * 48'(s2_om_q);
      s3_m_q     <= s2_m_q;
      s3_rb_q    <= s2_rb_q;
      s3_flags_q <= s2_flags_q;

      // bias numerator carries the factor 256 and the doubling for rounding
      s4_tmo_q   <= TmoW'(s3_ptm0_q) + (TmoW'(s3_ptm1_q) << 32);
      s4_bnum_q  <= (BiasNumW'(s3_pbm0_q) + (BiasNumW'(s3_pbm1_q) << 32)) << 9;
      s4_s_q     <= s3_s_q;
      s4_m_q     <= s3_m_q;
      s4_rb_q    <= s3_rb_q;
      s4_flags_q <= s3_flags_q;

      s5_p00_q   <= 64'(s4_tmo_q[31:0]) * 64'(s4_s_q[31:0]);
      s5_p01_q   <= 56'(s4_tmo_q[31:0]) * 56'(s4_s_q[55:32]);
      s5_p10_q   <= 64'(s4_tmo_q[63:32]) * 64'(s4_s_q[31:0]);
      s5_p11_q   <= 56'(s4_tmo_q[63:32]) * 56'(s4_s_q[55:32]);
      s5_p20_q   <= 54'(s4_tmo_q[85:64]) * 54'(s4_s_q[31:0]);
      s5_p21_q   <= 46'(s4_tmo_q[85:64]) * 46'(s4_s_q[55:32]);
      s5_bnum_q  <= s4_bnum_q;
      s5_s_q     <= s4_s_q;
      s5_m_q     <= s4_m_q;
      s5_rb_q    <= s4_rb_q;
      s5_flags_q <= s4_flags_q;

      s6_d_q     <= DW'(s5_p00_q) + (DW'(s5_p01_q) << 32) + (DW'(s5_p10_q) << 32)
                  + (DW'(s5_p11_q) << 64) + (DW'(s5_p20_q) << 64) + (DW'(s5_p21_q) << 96);
      s6_bnum_q  <= s5_bnum_q;
      s6_s_q     <= s5_s_q;
      s6_m_q     <= s5_m_q;
      s6_rb_q    <= s5_rb_q;
      s6_flags_q <= s5_flags_q;

      s7_q0_q    <= 63'(s6_m_q) * 63'(s6_d_q[31:0]);
      s7_q1_q    <= 63'(s6_m_q) * 63'(s6_d_q[63:32]);
      s7_q2_q    <= 63'(s6_m_q) * 63'(s6_d_q[95:64]);
      s7_q3_q    <= 63'(s6_m_q) * 63'(s6_d_q[127:96]);
      s7_q4_q    <= 45'(s6_m_q) * 45'(s6_d_q[141:128]);
      s7_den_q   <= (SoftDenW'(s6_m_q) << 88) + SoftDenW'(s6_d_q);
      s7_d_q     <= s6_d_q;
      s7_bnum_q  <= s6_bnum_q;
      s7_s_q     <= s6_s_q;
      s7_m_q     <= s6_m_q;
      s7_rb_q    <= s6_rb_q;
      s7_flags_q <= s6_flags_q;

      s8_num_q   <= (SoftNumW'(s7_q0_q) + (SoftNumW'(s7_q1_q) << 32)
                   + (SoftNumW'(s7_q2_q) << 64) + (SoftNumW'(s7_q3_q) << 96)
                   + (SoftNumW'(s7_q4_q) << 128)) << 1;
      s8_den_q   <= s7_den_q;
      s8_d_q     <= s7_d_q;
      s8_bnum_q  <= s7_bnum_q;
      s8_s_q     <= s7_s_q;
      s8_side_q.flags      <= s7_flags_q;
      s8_side_q.mass       <= s7_m_q;
      s8_side_q.rigid_bias <= s7_rb_q;
    end
  end

  assign valid_o    = v_q[FrontLat-1];
  assign side_o     = s8_side_q;
  assign gam_den_o  = s8_d_q;
  assign soft_num_o = s8_num_q;
  assign soft_den_o = s8_den_q;
  assign bias_num_o = s8_bnum_q;
  assign bias_den_o = s8_s_q;

endmodule

/* hw/rtl/scc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module scc_div
  import scc_pkg::*;
#(
  parameter int NUM_W = GamNumW,
  parameter int DEN_W = DW,
  parameter int QUO_W = QuoW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int RemW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [RemW-1:0]  rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      // flag quotients that do not fit in QUO_W bits
      ovf_q[0] <= RemW'(num_i) >= (RemW'(den_i) << QUO_W);
      // one quotient bit per stage, most significant first
      for (int k = 1; k <= QUO_W; k++) begin
        if (rem_q[k-1] >= (RemW'(den_q[k-1]) << (QUO_W - k))) begin
          rem_q[k] <= rem_q[k-1] - (RemW'(den_q[k-1]) << (QUO_W - k));
          quo_q[k] <= quo_q[k-1] | (QUO_W'(1) << (QUO_W - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

/* hw/rtl/scc_back.sv */
// Rounding, saturation, path selection and the output register.
module scc_back
  import scc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  scc_side_t       side_i,
  input  logic [QuoW-1:0] gam_quo_i,
  input  logic            gam_ovf_i,
  input  logic [QuoW-1:0] soft_quo_i,
  input  logic            soft_ovf_i,
  input  logic [QuoW-1:0] bias_quo_i,
  input  logic            bias_ovf_i,
  output logic            valid_o,
  output scc_out_t        data_o
);

  localparam logic [QuoW-1:0] Max31 = 33'h0_7FFF_FFFF;
  localparam logic [QuoW-1:0] Min31 = 33'h0_8000_0000;

  // quotients come in half units: add one half and drop it
  function automatic logic [QuoW-1:0] round_half(input logic [QuoW-1:0] q);
    round_half = QuoW'((34'(q) + 34'd1) >> 1);
  endfunction

  logic [QuoW-1:0] lim, gr, sr, br, bmag, rmag, mag;
  logic            gsat, ssat, bsat, rsat;
  scc_out_t        res;
  logic            valid_q;
  scc_out_t        data_q;

  always_comb begin
    lim  = side_i.flags.neg ? Min31 : Max31;
    gr   = round_half(gam_quo_i);
    sr   = round_half(soft_quo_i);
    br   = round_half(bias_quo_i);
    gsat = gam_ovf_i || (gr > Max31);
    ssat = soft_ovf_i || (sr > Max31);
    bsat = bias_ovf_i || (br > lim);
    bmag = bsat ? lim : br;
    rsat = side_i.rigid_bias > RbW'(lim);
    rmag = rsat ? lim : side_i.rigid_bias[QuoW-1:0];

    if (side_i.flags.rigid) begin
      mag            = rmag;
      res.soft_mass  = side_i.mass;
      res.gamma_term = '0;
      res.saturated  = rsat;
    end else if (side_i.flags.tzero) begin
      mag            = '0;
      res.soft_mass  = side_i.mass;
      res.gamma_term = '0;
      res.saturated  = 1'b0;
    end else begin
      mag            = bmag;
      res.soft_mass  = ssat ? Max31[30:0] : sr[30:0];
      res.gamma_term = gsat ? Max31[30:0] : gr[30:0];
      res.saturated  = gsat || ssat || bsat;
    end
    res.bias_term = side_i.flags.neg ? 32'(33'd0 - mag) : 32'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= res;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/soft_constraint_coefficients.sv */
// Top level of the soft constraint coefficient pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | request   | in_valid / stall   | scc_in_t: mass, error, freq, zeta
//  out     | result    | out_valid / stall  | scc_out_t: bias, mass, gamma, sat
//  cfg     | write     | cfg_valid / ready  | index 0 baumgarte, 1 time step
//
// One request per cycle enters and one result per cycle leaves while no result is
// stalled; the path is 8 front stages, 34 divider stages and one output register.
// The divider pipeline, one quotient bit per stage, sets that depth.
// Reset clears the valid bits and loads the reset values of both registers.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module soft_constraint_coefficients
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  scc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output scc_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam logic [GamNumW-1:0] GamNum = GamNumW'(1) << (GamNumW - 1);

  logic [BaumW-1:0] baum_q;
  logic [StepW-1:0] step_q;
  logic             en;

  logic                fr_valid;
  scc_side_t           fr_side;
  logic [DW-1:0]       gam_den;
  logic [SoftNumW-1:0] soft_num;
  logic [SoftDenW-1:0] soft_den;
  logic [BiasNumW-1:0] bias_num;
  logic [SW-1:0]       bias_den;

  logic [QuoW-1:0] gam_quo, soft_quo, bias_quo;
  logic            gam_ovf, soft_ovf, bias_ovf;

  logic [DivLat-1:0] dl_v_q;
  scc_side_t         dl_side_q [DivLat];

  // advance everything unless a finished result is held up
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baum_q <= BaumReset;
      step_q <= StepReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBaumgarte: baum_q <= cfg_data_i[BaumW-1:0];
        CfgTimeStep:  step_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  scc_front u_front (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (in_valid_i),
    .data_i     (in_data_i),
    .baum_i     (baum_q),
    .step_i     (step_q),
    .valid_o    (fr_valid),
    .side_o     (fr_side),
    .gam_den_o  (gam_den),
    .soft_num_o (soft_num),
    .soft_den_o (soft_den),
    .bias_num_o (bias_num),
    .bias_den_o (bias_den)
  );

  // gamma = 2^120 / D, soft mass = m*D / (m*2^88 + D), bias = b*|e|*om*256 / S
  scc_div #(.NUM_W(GamNumW), .DEN_W(DW), .QUO_W(QuoW)) u_div_gam (
    .clk_i, .en_i(en), .num_i(GamNum), .den_i(gam_den), .quo_o(gam_quo), .ovf_o(gam_ovf)
  );

  scc_div #(.NUM_W(SoftNumW), .DEN_W(SoftDenW), .QUO_W(QuoW)) u_div_soft (
    .clk_i, .en_i(en), .num_i(soft_num), .den_i(soft_den), .quo_o(soft_quo),
    .ovf_o(soft_ovf)
  );

  scc_div #(.NUM_W(BiasNumW), .DEN_W(SW), .QUO_W(QuoW)) u_div_bias (
    .clk_i, .en_i(en), .num_i(bias_num), .den_i(bias_den), .quo_o(bias_quo),
    .ovf_o(bias_ovf)
  );

  // carry valid bits and row flags alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_v_q <= '0;
    end else if (en) begin
      dl_v_q <= {dl_v_q[DivLat-2:0], fr_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_side_q[0] <= fr_side;
      for (int i = 1; i < DivLat; i++) begin
        dl_side_q[i] <= dl_side_q[i-1];
      end
    end
  end

  scc_back u_back (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (dl_v_q[DivLat-1]),
    .side_i     (dl_side_q[DivLat-1]),
    .gam_quo_i  (gam_quo),
    .gam_ovf_i  (gam_ovf),
    .soft_quo_i (soft_quo),
    .soft_ovf_i (soft_ovf),
    .bias_quo_i (bias_quo),
    .bias_ovf_i (bias_ovf),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o)
  );

`ifndef SYNTHESIS
  // rigid rows leave with no softness term
  a_rigid_gamma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dl_v_q[DivLat-1] && dl_side_q[DivLat-1].flags.rigid)
      |=> (out_valid_o && (out_data_o.gamma_term == '0)))
    else $error("rigid row produced nonzero gamma");

  // softening never raises the mass
  a_soft_le_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dl_v_q[DivLat-1])
      |=> (out_data_o.soft_mass <= $past(dl_side_q[DivLat-1].mass)))
    else $error("soft mass above effective mass");

  // a stall freezes the divider valid line
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dl_v_q))
    else $error("pipeline advanced during stall");
`endif

endmodule
